// ===== rtl/core/stlin_pkg.sv =====
// Shared types, constants and breakpoint tables for the sensor table linearizer.
// No dependencies; imported by stlin_div, sensor_table_linearizer and the testbench.
package stlin_pkg;

	// field and datapath widths
	localparam int PT_W    = 16;              // reading / breakpoint width
	localparam int RES_W   = 15;              // signed result width
	localparam int STEP_W  = 10;              // largest step is 1000
	localparam int QUO_W   = STEP_W;          // quotient < step < 2**STEP_W
	localparam int NUM_W   = PT_W + STEP_W;   // (x - pt) * step
	localparam int CNT_W   = $clog2(QUO_W);
	localparam int TIDX_W  = 6;               // table index, up to 64 points
	localparam int TCNT_W  = 7;               // point count, up to 64
	localparam int MODE_W  = 2;

	// sensor_mode codes (unused code falls back to PT100)
	localparam logic [MODE_W-1:0] MODE_PT100 = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RTD2  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SOIL  = 2'd2;

	// range_status codes
	localparam logic [1:0] RS_WITHIN = 2'd0;
	localparam logic [1:0] RS_BELOW  = 2'd1;
	localparam logic [1:0] RS_ABOVE  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK_LO,
		ST_CHK_HI,
		ST_SEARCH,
		ST_FETCH_LO,
		ST_FETCH_HI,
		ST_DIV,
		ST_DONE
	} lin_state_t;

	// divider handshake toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [TCNT_W-1:0] tab_count(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_RTD2: tab_count = 7'd13;
			MODE_SOIL: tab_count = 7'd21;
			default:   tab_count = 7'd15;
		endcase
	endfunction

	function automatic logic signed [RES_W-1:0] tab_first(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_SOIL: tab_first = 15'sd0;
			default:   tab_first = -15'sd6000;
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] tab_step(input logic [MODE_W-1:0] mode);
		case (mode)
			MODE_SOIL: tab_step = 10'd500;
			default:   tab_step = 10'd1000;
		endcase
	endfunction

	function automatic logic [PT_W-1:0] tab_point(input logic [MODE_W-1:0] mode,
		input logic [TIDX_W-1:0] idx);
		logic [PT_W-1:0] p;
		p = '0;
		case (mode)
			MODE_RTD2: begin
				case (idx)
					6'd0:    p = 16'd7641;
					6'd1:    p = 16'd8048;
					6'd2:    p = 16'd8445;
					6'd3:    p = 16'd8842;
					6'd4:    p = 16'd9236;
					6'd5:    p = 16'd9630;
					6'd6:    p = 16'd10023;
					6'd7:    p = 16'd10413;
					6'd8:    p = 16'd10803;
					6'd9:    p = 16'd11191;
					6'd10:   p = 16'd11578;
					6'd11:   p = 16'd11964;
					6'd12:   p = 16'd12350;
					default: p = '0;
				endcase
			end
			MODE_SOIL: begin
				case (idx)
					6'd0:    p = 16'd115;
					6'd1:    p = 16'd340;
					6'd2:    p = 16'd450;
					6'd3:    p = 16'd530;
					6'd4:    p = 16'd610;
					6'd5:    p = 16'd690;
					6'd6:    p = 16'd750;
					6'd7:    p = 16'd825;
					6'd8:    p = 16'd895;
					6'd9:    p = 16'd955;
					6'd10:   p = 16'd1005;
					6'd11:   p = 16'd1015;
					6'd12:   p = 16'd1025;
					6'd13:   p = 16'd1035;
					6'd14:   p = 16'd1045;
					6'd15:   p = 16'd1055;
					6'd16:   p = 16'd1065;
					6'd17:   p = 16'd1070;
					6'd18:   p = 16'd1080;
					6'd19:   p = 16'd1095;
					6'd20:   p = 16'd1106;
					default: p = '0;
				endcase
			end
			default: begin
				case (idx)
					6'd0:    p = 16'd7633;
					6'd1:    p = 16'd8031;
					6'd2:    p = 16'd8427;
					6'd3:    p = 16'd8822;
					6'd4:    p = 16'd9216;
					6'd5:    p = 16'd9609;
					6'd6:    p = 16'd10000;
					6'd7:    p = 16'd10390;
					6'd8:    p = 16'd10779;
					6'd9:    p = 16'd11167;
					6'd10:   p = 16'd11554;
					6'd11:   p = 16'd11940;
					6'd12:   p = 16'd12324;
					6'd13:   p = 16'd12707;
					6'd14:   p = 16'd13089;
					default: p = '0;
				endcase
			end
		endcase
		tab_point = p;
	endfunction

endpackage

// ===== rtl/core/stlin_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on stlin_pkg. Requires num < den * 2**QUO_W.
module stlin_div
	import stlin_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [PT_W-1:0]  den,
	output div_stat_t        stat,
	output logic [QUO_W-1:0] quot
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PT_W-1:0]  rem_q;
	logic [PT_W-1:0]  den_q;
	logic [QUO_W-1:0] low_q;
	logic [QUO_W-1:0] quot_q;
	logic [PT_W:0]    trial;
	logic [PT_W:0]    sub;
	logic             ge;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, low_q[QUO_W-1]};
		sub   = trial - {1'b0, den_q};
		ge    = (trial >= {1'b0, den_q});
	end

	// control: busy while the quotient bits shift in, then a one-cycle done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder / dividend shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-1:QUO_W];
			low_q  <= num[QUO_W-1:0];
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? sub[PT_W-1:0] : trial[PT_W-1:0];
			low_q  <= {low_q[QUO_W-2:0], 1'b0};
			quot_q <= {quot_q[QUO_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

// ===== rtl/core/sensor_table_linearizer.sv =====
// Sensor table linearizer top level: breakpoint search, segment fetch, serial divide.
// Depends on stlin_pkg and stlin_div.
//
//  channel   signals                                    direction
//  in        in_valid, in_ready, reading                request in
//  out       out_valid, out_ready, value_hundredths,    request out
//            range_status
//  cfg       cfg_wr_en, cfg_wr_data (sensor_mode)       write only
//
// A request passes through idle, two range checks, a halving binary search, two fetch
// states, the serial divide and done; clamped or on-breakpoint readings skip the divider.
// The bit-serial divider is the slowest step. One request is in flight; in_ready is
// high only when idle. The result register holds a finished request while out_ready is
// low and the block takes the next request meanwhile. Reset clears control and sensor_mode.
module sensor_table_linearizer
	import stlin_pkg::*;
#(
	parameter int MAX_TABLE_POINTS = 21
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [PT_W-1:0]         reading,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [RES_W-1:0] value_hundredths,
	output logic [1:0]              range_status,
	input  logic                    cfg_wr_en,
	input  logic [MODE_W-1:0]       cfg_wr_data
);

	localparam int IDX_W = $clog2(MAX_TABLE_POINTS);

	lin_state_t state_q, state_d;

	logic [MODE_W-1:0]       mode_q;
	logic [PT_W-1:0]         x_q;
	logic [IDX_W-1:0]        lo_q;
	logic [IDX_W-1:0]        hi_q;
	logic [PT_W-1:0]         pl_q;
	logic [NUM_W-1:0]        num_q;
	logic signed [RES_W-1:0] res_q;
	logic [1:0]              rs_q;
	logic                    interp_q;
	logic                    out_valid_q;
	logic signed [RES_W-1:0] out_val_q;
	logic [1:0]              out_rs_q;

	logic [TCNT_W-1:0]       cnt_w;
	logic [IDX_W-1:0]        last_w;
	logic [IDX_W:0]          mid_sum;
	logic [IDX_W-1:0]        mid_w;
	logic                    span_gt1;
	logic [IDX_W-1:0]        tab_idx;
	logic [IDX_W-1:0]        mul_idx;
	logic [PT_W-1:0]         pt_w;
	logic [PT_W-1:0]         den_w;
	logic [RES_W-1:0]        base_w;
	logic [NUM_W-1:0]        prod_w;
	logic                    div_start;
	logic                    out_load;
	div_stat_t               div_stat;
	logic [QUO_W-1:0]        quot_w;

	// table geometry, count clipped to the parameter
	always_comb begin
		cnt_w    = tab_count(mode_q);
		last_w   = (cnt_w > TCNT_W'(MAX_TABLE_POINTS)) ? IDX_W'(MAX_TABLE_POINTS - 1)
		                                               : IDX_W'(cnt_w - TCNT_W'(1));
		mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
		mid_w    = mid_sum[IDX_W:1];
		span_gt1 = ({1'b0, hi_q} - {1'b0, lo_q}) > (IDX_W+1)'(1);
	end

	// table read, base value and scaled offset
	always_comb begin
		pt_w   = tab_point(mode_q, TIDX_W'(tab_idx));
		den_w  = pt_w - pl_q;
		base_w = RES_W'(tab_first(mode_q)) + RES_W'(mul_idx) * RES_W'(tab_step(mode_q));
		prod_w = NUM_W'(x_q - pt_w) * NUM_W'(tab_step(mode_q));
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_CHK_LO;
			ST_CHK_LO:   state_d = (x_q < pt_w) ? ST_DONE : ST_CHK_HI;
			ST_CHK_HI:   state_d = (x_q > pt_w) ? ST_DONE : ST_SEARCH;
			ST_SEARCH:   if (!span_gt1) state_d = ST_FETCH_LO;
			ST_FETCH_LO: state_d = (lo_q == last_w || x_q == pt_w) ? ST_DONE : ST_FETCH_HI;
			ST_FETCH_HI: state_d = (den_w != '0) ? ST_DIV : ST_DONE;
			ST_DIV:      if (div_stat.done) state_d = ST_DONE;
			ST_DONE:     if (out_load) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// control outputs: table index, multiplier index, divider start
	always_comb begin
		in_ready  = 1'b0;
		tab_idx   = lo_q;
		mul_idx   = lo_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:     in_ready = 1'b1;
			ST_CHK_LO:   tab_idx = '0;
			ST_CHK_HI: begin
				tab_idx = hi_q;
				mul_idx = hi_q;
			end
			ST_SEARCH:   tab_idx = span_gt1 ? mid_w : hi_q;
			ST_FETCH_LO: tab_idx = lo_q;
			ST_FETCH_HI: begin
				tab_idx   = lo_q + IDX_W'(1);
				div_start = (den_w != '0);
			end
			default:     tab_idx = lo_q;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_PT100;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x_q  <= reading;
					lo_q <= '0;
					hi_q <= last_w;
				end
			end
			ST_CHK_LO: begin
				res_q    <= tab_first(mode_q);
				rs_q     <= RS_BELOW;
				interp_q <= 1'b0;
			end
			ST_CHK_HI: begin
				res_q <= base_w;
				rs_q  <= (x_q > pt_w) ? RS_ABOVE : RS_WITHIN;
			end
			ST_SEARCH: begin
				if (span_gt1) begin
					if (x_q < pt_w) hi_q <= mid_w;
					else lo_q <= mid_w;
				end else if (x_q >= pt_w) begin
					lo_q <= hi_q;
				end
			end
			ST_FETCH_LO: begin
				res_q <= base_w;
				pl_q  <= pt_w;
				num_q <= prod_w;
			end
			ST_FETCH_HI: interp_q <= (den_w != '0);
			default: begin
			end
		endcase
		if (out_load) begin
			out_val_q <= interp_q ? res_q + RES_W'(quot_w) : res_q;
			out_rs_q  <= rs_q;
		end
	end

	stlin_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_w),
		.stat   (div_stat),
		.quot   (quot_w)
	);

	assign out_valid        = out_valid_q;
	assign value_hundredths = out_val_q;
	assign range_status     = out_rs_q;

endmodule

// ===== tb/sensor_table_linearizer_tb.sv =====
// Self-checking testbench for sensor_table_linearizer: breakpoint-table linearization per mode.
// Depends on stlin_pkg and the RTL; a scoreboard class predicts each request, plain tasks drive.
module sensor_table_linearizer_tb
	import stlin_pkg::*;
();

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;   // falls back to PT100
	localparam int STALL_LIMIT = 5000;                  // cycles with no request moving
	localparam int SEG_ITEMS   = 75;
	localparam int NUM_SEGS    = 12;

	// breakpoint tables, indexed by table select (0 PT100, 1 second RTD, 2 soil)
	localparam int NPTS [3] = '{15, 13, 21};
	localparam int BASE [3] = '{-6000, -6000, 0};
	localparam int INCR [3] = '{1000, 1000, 500};
	localparam int BRK [3][21] = '{
		'{7633, 8031, 8427, 8822, 9216, 9609, 10000, 10390, 10779, 11167, 11554,
		  11940, 12324, 12707, 13089, 0, 0, 0, 0, 0, 0},
		'{7641, 8048, 8445, 8842, 9236, 9630, 10023, 10413, 10803, 11191, 11578,
		  11964, 12350, 0, 0, 0, 0, 0, 0, 0, 0},
		'{115, 340, 450, 530, 610, 690, 750, 825, 895, 955, 1005,
		  1015, 1025, 1035, 1045, 1055, 1065, 1070, 1080, 1095, 1106}
	};

	typedef struct {
		logic signed [RES_W-1:0] value;
		logic [1:0]              status;
	} lin_result_t;

	// predicts the linearized value of every accepted reading, checks results in order
	class lin_scoreboard;
		logic [MODE_W-1:0] mode;
		lin_result_t       pending_q[$];
		int                errors;

		function new();
			mode   = MODE_PT100;
			errors = 0;
		endfunction

		function void set_mode(logic [MODE_W-1:0] m);
			mode = m;
		endfunction

		function int outstanding();
			return pending_q.size();
		endfunction

		// work out the expected result of one reading under the current mode
		function void note_input(logic [PT_W-1:0] x);
			lin_result_t exp_r;
			int sel, n, k, xi, acc;
			sel = (mode == MODE_UNUSED) ? 0 : int'(mode);
			n   = NPTS[sel];
			xi  = int'(x);
			exp_r.status = RS_WITHIN;
			if (xi < BRK[sel][0]) begin
				acc = BASE[sel];
				exp_r.status = RS_BELOW;
			end else if (xi > BRK[sel][n-1]) begin
				acc = BASE[sel] + (n - 1) * INCR[sel];
				exp_r.status = RS_ABOVE;
			end else begin
				// last breakpoint at or below the reading
				k = 0;
				for (int i = 1; i < n; i++)
					if (BRK[sel][i] <= xi)
						k = i;
				acc = BASE[sel] + k * INCR[sel];
				if (k < n - 1 && xi > BRK[sel][k])
					acc += ((xi - BRK[sel][k]) * INCR[sel]) / (BRK[sel][k+1] - BRK[sel][k]);
			end
			exp_r.value = RES_W'(acc);
			pending_q.push_back(exp_r);
		endfunction

		function void check_result(logic signed [RES_W-1:0] v, logic [1:0] s);
			lin_result_t exp_r;
			if (pending_q.size() == 0) begin
				$error("result with nothing pending: value_hundredths %0d, range_status %0d", v, s);
				errors++;
				return;
			end
			exp_r = pending_q.pop_front();
			if (v !== exp_r.value) begin
				$error("value_hundredths: expected %0d, got %0d", exp_r.value, v);
				errors++;
			end
			if (s !== exp_r.status) begin
				$error("range_status: expected %0d, got %0d", exp_r.status, s);
				errors++;
			end
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [PT_W-1:0]         reading = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic signed [RES_W-1:0] value_hundredths;
	logic [1:0]              range_status;
	logic                    cfg_wr_en = 1'b0;
	logic [MODE_W-1:0]       cfg_wr_data = '0;

	lin_scoreboard sb = new();
	int tx_idle_pct = 34;
	int rx_idle_pct = 81;
	int stall_cycles = 0;

	sensor_table_linearizer i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.reading          (reading),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.value_hundredths (value_hundredths),
		.range_status     (range_status),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side: random back-pressure, check on every transfer, stall watchdog
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(value_hundredths, range_status);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("*** FAILED ***");
		$finish;
	end

	// send one request, with a random idle gap ahead of it
	task automatic push_reading(input logic [PT_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		reading  <= v;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(v);
	endtask

	// hold off the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	task automatic set_mode(input logic [MODE_W-1:0] m);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_mode(m);
	endtask

	// mostly readings around the active table, some on breakpoints, some anywhere
	function automatic logic [PT_W-1:0] pick_reading(input logic [MODE_W-1:0] m);
		int sel, lo, hi, k, roll;
		sel  = (m == MODE_UNUSED) ? 0 : int'(m);
		lo   = BRK[sel][0];
		hi   = BRK[sel][NPTS[sel]-1];
		roll = $urandom_range(99);
		if (roll < 60)
			return PT_W'($urandom_range(hi + 25, lo - 25));
		if (roll < 80) begin
			k = $urandom_range(NPTS[sel] - 1);
			return PT_W'(BRK[sel][k] + int'($urandom_range(2)) - 1);
		end
		return PT_W'($urandom_range(16'hFFFF));
	endfunction

	initial begin
		logic [PT_W-1:0]   dir_q[$];
		logic [MODE_W-1:0] m;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: table ends, one off each end, breakpoints, narrow segments
		set_mode(MODE_PT100);
		dir_q = '{16'd0, 16'hFFFF, 16'd7632, 16'd7633, 16'd7634, 16'd13088,
			16'd13089, 16'd13090, 16'd10000, 16'd10389};
		foreach (dir_q[i]) push_reading(dir_q[i]);
		drain();
		set_mode(MODE_RTD2);
		dir_q = '{16'd7640, 16'd7641, 16'd12350, 16'd12351, 16'd9999};
		foreach (dir_q[i]) push_reading(dir_q[i]);
		drain();
		set_mode(MODE_SOIL);
		dir_q = '{16'd114, 16'd115, 16'd1106, 16'd1107, 16'd1010, 16'd1067};
		foreach (dir_q[i]) push_reading(dir_q[i]);
		drain();
		set_mode(MODE_UNUSED);
		dir_q = '{16'd7633, 16'd13089, 16'd32768};
		foreach (dir_q[i]) push_reading(dir_q[i]);

		// random: three idling phases, each sweeping all four mode codes
		for (int seg = 0; seg < NUM_SEGS; seg++) begin
			drain();
			case (seg / 4)
				0: begin
					tx_idle_pct = 34;
					rx_idle_pct = 81;
				end
				1: begin
					tx_idle_pct = 81;
					rx_idle_pct = 34;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			m = MODE_W'(seg % 4);
			set_mode(m);
			repeat (SEG_ITEMS) push_reading(pick_reading(m));
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d results never arrived", sb.outstanding());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sensor_table_linearizer.f =====
rtl/core/stlin_pkg.sv
rtl/core/stlin_div.sv
rtl/core/sensor_table_linearizer.sv
tb/sensor_table_linearizer_tb.sv
